/* src/mitint_pkg.sv */
package mitint_pkg;

  localparam int MITINT_TABLE_DEPTH = 1024;
  localparam int MITINT_FRAC_BITS   = 8;

  // Field widths
  localparam int FLUX_W   = 18;
  localparam int AP_W     = 17;
  localparam int YEAR_W   = 14;
  localparam int DAY_W    = 9;
  localparam int EFLUX_W  = 10;
  localparam int EAP_W    = 9;
  localparam int EIDX_W   = 10;
  localparam int USED_W   = 11;
  localparam int CFG_W    = 18;
  localparam int CFG_IDX_W = 3;

  // Interpolation numerator: entry (10 bits) times month length (up to 31)
  localparam int NUM_W = 15;
  // Month index: month + 12 * (year - base_year)
  localparam int IDX_W = 18;
  // Divisor width of the serial dividers (month length or point count)
  localparam int DSR_W = 5;

  localparam int MONTHS_PER_YEAR = 12;
  localparam int CENTURY         = 100;
  // floor(y / 100) == (y * DIV100_MUL) >> DIV100_SHIFT for all 14-bit y
  localparam int DIV100_MUL   = 5243;
  localparam int DIV100_SHIFT = 19;
  localparam int YMUL_W       = 27;
  localparam int YCENT_W      = YMUL_W - DIV100_SHIFT;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_YEAR      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_USED   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OVR_ENABLE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OVR_FLUX_DAILY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OVR_FLUX_AVG   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OVR_AP         = 3'd5;

  // Result status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_OUTSIDE = 2'd1;
  localparam logic [1:0] STATUS_BAD_DAY = 2'd2;

  typedef enum logic [1:0] {
    RD_CUR = 2'd0,
    RD_NXT = 2'd1,
    RD_PRV = 2'd2
  } rd_sel_e;

  typedef enum logic [1:0] {
    RES_OK       = 2'd0,
    RES_OUTSIDE  = 2'd1,
    RES_BAD_DAY  = 2'd2,
    RES_OVERRIDE = 2'd3
  } res_sel_e;

  typedef struct packed {
    logic                 kind;
    logic [EIDX_W-1:0]    entry_index;
    logic [EFLUX_W-1:0]   entry_flux;
    logic [EAP_W-1:0]     entry_ap;
    logic [DAY_W-1:0]     day_of_year;
    logic [YEAR_W-1:0]    query_year;
  } mitint_req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [3:0]           month_number;
    logic [4:0]           day_of_month;
    logic [4:0]           month_length;
    logic [FLUX_W-1:0]    flux_daily;
    logic [FLUX_W-1:0]    flux_avg;
    logic [AP_W-1:0]      ap_daily;
  } mitint_res_t;

  typedef struct packed {
    logic     ld_query;
    logic     wr_entry;
    logic     year_mul;
    logic     leap;
    logic     walk_step;
    logic     calc_index;
    logic     chk_range;
    rd_sel_e  rd_sel;
    logic     cap_cur;
    logic     cap_nxt;
    logic     cap_prv;
    logic     mul;
    logic     div_load;
    logic     div_step;
    logic     ld_out;
    res_sel_e res_sel;
  } mitint_cmd_t;

  typedef struct packed {
    logic day_bad;
    logic walk_more;
    logic override;
    logic outside;
  } mitint_sts_t;

  function automatic logic [4:0] month_days(input logic leap, input logic [3:0] month);
    logic [4:0] len;
    case (month)
      4'd1:    len = leap ? 5'd29 : 5'd28;
      4'd3:    len = 5'd30;
      4'd5:    len = 5'd30;
      4'd8:    len = 5'd30;
      4'd10:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

/* src/mitint_div.sv */
module mitint_div import mitint_pkg::*; #(
  parameter int DVW = NUM_W + MITINT_FRAC_BITS,
  parameter int VW  = DSR_W
) (
  input  logic           clk_i,
  input  logic           load_i,
  input  logic           step_i,
  input  logic [DVW-1:0] dividend_i,
  input  logic [VW-1:0]  divisor_i,
  output logic [DVW-1:0] quot_o
);

  // Restoring division, one quotient bit per step; dividend shifts out as
  // quotient shifts in.
  logic [DVW-1:0] quo_q, quo_d;
  logic [VW-1:0]  rem_q, rem_d;
  logic [VW-1:0]  dsr_q;
  logic [VW:0]    trial;
  logic [VW:0]    diff;
  logic           ge;

  always_comb begin
    trial = {rem_q, quo_q[DVW-1]};
    diff  = trial - {1'b0, dsr_q};
    ge    = (trial >= {1'b0, dsr_q});
    rem_d = ge ? diff[VW-1:0] : trial[VW-1:0];
    quo_d = {quo_q[DVW-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (step_i) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign quot_o = quo_q;

endmodule

/* src/mitint_dp.sv */
module mitint_dp import mitint_pkg::*; #(
  parameter int TABLE_DEPTH = MITINT_TABLE_DEPTH,
  parameter int FRAC_BITS   = MITINT_FRAC_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  mitint_req_t          in_req_i,
  input  mitint_cmd_t          cmd_i,
  output mitint_sts_t          sts_o,
  output mitint_res_t          out_res_o
);

  localparam int AW   = $clog2(TABLE_DEPTH);
  localparam int IW   = (AW > EIDX_W) ? AW : EIDX_W;
  localparam int EW   = (AW + 1 > USED_W) ? AW + 1 : USED_W;
  localparam int DVW  = NUM_W + FRAC_BITS;
  localparam int MW   = EFLUX_W + EAP_W;

  // Configuration registers
  logic [YEAR_W-1:0] base_year_q;
  logic [USED_W-1:0] entries_used_q;
  logic              ovr_en_q;
  logic [FLUX_W-1:0] ovr_flux_daily_q;
  logic [FLUX_W-1:0] ovr_flux_avg_q;
  logic [AP_W-1:0]   ovr_ap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_year_q      <= '0;
      entries_used_q   <= '0;
      ovr_en_q         <= 1'b0;
      ovr_flux_daily_q <= '0;
      ovr_flux_avg_q   <= '0;
      ovr_ap_q         <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BASE_YEAR:      base_year_q      <= cfg_data_i[YEAR_W-1:0];
        CFG_ENTRIES_USED:   entries_used_q   <= cfg_data_i[USED_W-1:0];
        CFG_OVR_ENABLE:     ovr_en_q         <= cfg_data_i[0];
        CFG_OVR_FLUX_DAILY: ovr_flux_daily_q <= cfg_data_i[FLUX_W-1:0];
        CFG_OVR_FLUX_AVG:   ovr_flux_avg_q   <= cfg_data_i[FLUX_W-1:0];
        CFG_OVR_AP:         ovr_ap_q         <= cfg_data_i[AP_W-1:0];
        default: ;
      endcase
    end
  end

  // Valid entry count, capped at the table depth
  logic [EW-1:0] used_w;
  logic [EW-1:0] count;
  assign used_w = EW'(entries_used_q);
  assign count  = (used_w > EW'(TABLE_DEPTH)) ? EW'(TABLE_DEPTH) : used_w;

  // Query registers
  logic [DAY_W-1:0]   day_q;
  logic [YEAR_W-1:0]  year_q;
  logic [YCENT_W-1:0] cent_q;
  logic               leap_q;
  logic               below_q;
  logic [YEAR_W-1:0]  rel_q;
  logic [3:0]         month_q;
  logic [DAY_W-1:0]   dom_q;
  logic [IDX_W-1:0]   idx_q;
  logic [4:0]         len_q;
  logic               has_nxt_q;
  logic               has_prv_q;

  logic [YMUL_W-1:0]  ymul;
  logic [YEAR_W-1:0]  yrem;
  logic               leap_d;
  logic [4:0]         md;
  logic [DAY_W-1:0]   ylen;
  logic [IDX_W-1:0]   idx_d;
  logic [IDX_W-1:0]   idx_p1;
  logic [IDX_W-1:0]   idx_m1;

  always_comb begin
    ymul   = YMUL_W'(year_q) * YMUL_W'(DIV100_MUL);
    yrem   = year_q - YEAR_W'(cent_q) * YEAR_W'(CENTURY);
    // Divisible by 400 means the century remainder is zero and the century
    // count divides by 4
    leap_d = (year_q[1:0] == 2'b00) && ((yrem != '0) || (cent_q[1:0] == 2'b00));
    md     = month_days(leap_q, month_q);
    ylen   = leap_q ? DAY_W'(366) : DAY_W'(365);
    idx_d  = IDX_W'(month_q) + IDX_W'(rel_q) * IDX_W'(MONTHS_PER_YEAR);
    idx_p1 = idx_q + IDX_W'(1);
    idx_m1 = idx_q - IDX_W'(1);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_query) begin
      day_q  <= in_req_i.day_of_year;
      year_q <= in_req_i.query_year;
    end
    if (cmd_i.year_mul) begin
      cent_q <= ymul[YMUL_W-1:DIV100_SHIFT];
    end
    if (cmd_i.leap) begin
      leap_q  <= leap_d;
      below_q <= (year_q < base_year_q);
      rel_q   <= year_q - base_year_q;
      month_q <= '0;
      dom_q   <= day_q;
    end
    if (cmd_i.walk_step) begin
      dom_q   <= dom_q - DAY_W'(md);
      month_q <= month_q + 4'd1;
    end
    if (cmd_i.calc_index) begin
      idx_q <= idx_d;
      len_q <= md;
    end
    if (cmd_i.chk_range) begin
      has_nxt_q <= (idx_p1 < IDX_W'(count));
      has_prv_q <= (idx_q != '0);
    end
  end

  assign sts_o.day_bad   = (day_q == '0) || (day_q > ylen);
  assign sts_o.walk_more = (dom_q > DAY_W'(md));
  assign sts_o.override  = ovr_en_q;
  assign sts_o.outside   = below_q || (idx_q >= IDX_W'(count));

  // Table memory: flux in the upper bits, Ap in the lower bits
  logic [MW-1:0] mem [TABLE_DEPTH];
  logic [MW-1:0] rdata_q;
  logic [IW-1:0] slot_w;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;

  assign slot_w = IW'(in_req_i.entry_index);
  assign waddr  = slot_w[AW-1:0];

  always_comb begin
    case (cmd_i.rd_sel)
      RD_NXT:  raddr = has_nxt_q ? idx_p1[AW-1:0] : idx_q[AW-1:0];
      RD_PRV:  raddr = idx_m1[AW-1:0];
      default: raddr = idx_q[AW-1:0];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_entry) begin
      mem[waddr] <= {in_req_i.entry_flux, in_req_i.entry_ap};
    end
    rdata_q <= mem[raddr];
  end

  // Entry registers and interpolation numerators
  logic [EFLUX_W-1:0] cur_f_q, nxt_f_q, prv_f_q;
  logic [EAP_W-1:0]   cur_a_q, nxt_a_q;
  logic [NUM_W-1:0]   num_f_q, num_a_q;
  logic [4:0]         kk;
  logic [4:0]         lmk;

  assign kk  = dom_q[4:0] - 5'd1;
  assign lmk = len_q - kk;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_cur) begin
      cur_f_q <= rdata_q[MW-1:EAP_W];
      cur_a_q <= rdata_q[EAP_W-1:0];
    end
    if (cmd_i.cap_nxt) begin
      nxt_f_q <= rdata_q[MW-1:EAP_W];
      nxt_a_q <= rdata_q[EAP_W-1:0];
    end
    if (cmd_i.cap_prv) begin
      prv_f_q <= rdata_q[MW-1:EAP_W];
    end
    if (cmd_i.mul) begin
      num_f_q <= NUM_W'(cur_f_q) * NUM_W'(lmk) + NUM_W'(nxt_f_q) * NUM_W'(kk);
      num_a_q <= NUM_W'(cur_a_q) * NUM_W'(lmk) + NUM_W'(nxt_a_q) * NUM_W'(kk);
    end
  end

  // Three-month flux sum over the neighbors that exist
  logic [NUM_W-1:0] fsum;
  logic [DSR_W-1:0] pts;

  always_comb begin
    fsum = NUM_W'(cur_f_q);
    pts  = DSR_W'(1);
    if (has_prv_q) begin
      fsum = fsum + NUM_W'(prv_f_q);
      pts  = pts + DSR_W'(1);
    end
    if (has_nxt_q) begin
      fsum = fsum + NUM_W'(nxt_f_q);
      pts  = pts + DSR_W'(1);
    end
  end

  logic [DVW-1:0] q_f, q_a, q_v;

  mitint_div #(.DVW(DVW), .VW(DSR_W)) u_div_flux (
    .clk_i      (clk_i),
    .load_i     (cmd_i.div_load),
    .step_i     (cmd_i.div_step),
    .dividend_i ({num_f_q, {FRAC_BITS{1'b0}}}),
    .divisor_i  (len_q),
    .quot_o     (q_f)
  );

  mitint_div #(.DVW(DVW), .VW(DSR_W)) u_div_ap (
    .clk_i      (clk_i),
    .load_i     (cmd_i.div_load),
    .step_i     (cmd_i.div_step),
    .dividend_i ({num_a_q, {FRAC_BITS{1'b0}}}),
    .divisor_i  (len_q),
    .quot_o     (q_a)
  );

  mitint_div #(.DVW(DVW), .VW(DSR_W)) u_div_avg (
    .clk_i      (clk_i),
    .load_i     (cmd_i.div_load),
    .step_i     (cmd_i.div_step),
    .dividend_i ({fsum, {FRAC_BITS{1'b0}}}),
    .divisor_i  (pts),
    .quot_o     (q_v)
  );

  // Saturate to field width
  logic [FLUX_W-1:0] sat_f, sat_v;
  logic [AP_W-1:0]   sat_a;

  assign sat_f = (|q_f[DVW-1:FLUX_W]) ? '1 : q_f[FLUX_W-1:0];
  assign sat_v = (|q_v[DVW-1:FLUX_W]) ? '1 : q_v[FLUX_W-1:0];
  assign sat_a = (|q_a[DVW-1:AP_W])   ? '1 : q_a[AP_W-1:0];

  mitint_res_t res_d, res_q;

  always_comb begin
    res_d              = '0;
    res_d.month_number = month_q + 4'd1;
    res_d.day_of_month = dom_q[4:0];
    res_d.month_length = len_q;
    case (cmd_i.res_sel)
      RES_BAD_DAY: begin
        res_d        = '0;
        res_d.status = STATUS_BAD_DAY;
      end
      RES_OVERRIDE: begin
        res_d.status     = STATUS_OK;
        res_d.flux_daily = ovr_flux_daily_q;
        res_d.flux_avg   = ovr_flux_avg_q;
        res_d.ap_daily   = ovr_ap_q;
      end
      RES_OUTSIDE: begin
        res_d.status = STATUS_OUTSIDE;
      end
      default: begin
        res_d.status     = STATUS_OK;
        res_d.flux_daily = sat_f;
        res_d.flux_avg   = sat_v;
        res_d.ap_daily   = sat_a;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_out) begin
      res_q <= res_d;
    end
  end

  assign out_res_o = res_q;

endmodule

/* src/mitint_ctrl.sv */
module mitint_ctrl import mitint_pkg::*; #(
  parameter int FRAC_BITS = MITINT_FRAC_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_kind_i,
  output logic        in_ready_o,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  input  mitint_sts_t sts_i,
  output mitint_cmd_t cmd_o
);

  localparam int DVW  = NUM_W + FRAC_BITS;
  localparam int CNTW = $clog2(DVW);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_YEAR   = 4'd1;
  localparam logic [3:0] S_LEAP   = 4'd2;
  localparam logic [3:0] S_CHECK  = 4'd3;
  localparam logic [3:0] S_WALK   = 4'd4;
  localparam logic [3:0] S_INDEX  = 4'd5;
  localparam logic [3:0] S_RANGE  = 4'd6;
  localparam logic [3:0] S_RD_CUR = 4'd7;
  localparam logic [3:0] S_RD_NXT = 4'd8;
  localparam logic [3:0] S_RD_PRV = 4'd9;
  localparam logic [3:0] S_MUL    = 4'd10;
  localparam logic [3:0] S_DLOAD  = 4'd11;
  localparam logic [3:0] S_DIV    = 4'd12;
  localparam logic [3:0] S_FINISH = 4'd13;

  logic [3:0]      state_q, state_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  res_sel_e        res_q, res_d;
  logic            out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_kind_i) begin
            cmd_o.ld_query = 1'b1;
            state_d        = S_YEAR;
          end else begin
            cmd_o.wr_entry = 1'b1;
          end
        end
      end
      S_YEAR: begin
        cmd_o.year_mul = 1'b1;
        state_d        = S_LEAP;
      end
      S_LEAP: begin
        cmd_o.leap = 1'b1;
        state_d    = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.day_bad) begin
          res_d   = RES_BAD_DAY;
          state_d = S_FINISH;
        end else begin
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        if (sts_i.walk_more) begin
          cmd_o.walk_step = 1'b1;
        end else begin
          state_d = S_INDEX;
        end
      end
      S_INDEX: begin
        cmd_o.calc_index = 1'b1;
        state_d          = S_RANGE;
      end
      S_RANGE: begin
        cmd_o.chk_range = 1'b1;
        if (sts_i.override) begin
          res_d   = RES_OVERRIDE;
          state_d = S_FINISH;
        end else if (sts_i.outside) begin
          res_d   = RES_OUTSIDE;
          state_d = S_FINISH;
        end else begin
          state_d = S_RD_CUR;
        end
      end
      S_RD_CUR: begin
        cmd_o.rd_sel = RD_CUR;
        state_d      = S_RD_NXT;
      end
      S_RD_NXT: begin
        cmd_o.rd_sel  = RD_NXT;
        cmd_o.cap_cur = 1'b1;
        state_d       = S_RD_PRV;
      end
      S_RD_PRV: begin
        cmd_o.rd_sel  = RD_PRV;
        cmd_o.cap_nxt = 1'b1;
        state_d       = S_MUL;
      end
      S_MUL: begin
        cmd_o.cap_prv = 1'b1;
        cmd_o.mul     = 1'b1;
        state_d       = S_DLOAD;
      end
      S_DLOAD: begin
        cmd_o.div_load = 1'b1;
        cnt_d          = CNTW'(DVW - 1);
        res_d          = RES_OK;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = S_FINISH;
        end else begin
          cnt_d = cnt_q - CNTW'(1);
        end
      end
      S_FINISH: begin
        cmd_o.res_sel = res_q;
        // Hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.ld_out = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      res_q       <= RES_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

/* src/monthly_index_table_interpolator_unit.sv */
// Monthly flux / Ap table with daily interpolation.
// Input channel (in_valid_i / in_ready_o / in_req_i): a load request (kind 0)
// writes one table slot and is taken while idle with no result; a
// query request (kind 1) gives day of year and year and yields one result on
// the output channel (out_valid_o / out_ready_i / out_res_o).
// A query runs year split, leap and day check, the month walk, index and
// range, three table reads, multiply, divider load, the divider steps and
// the result load. A bad day answers after the day check, an override or
// out-of-table query after the range check. Query time is set by the
// one-month-per-cycle walk and the bit-serial dividers for month length and
// point count, which run side by side.
// One query is in flight at a time; the next request is taken the cycle
// after the result is parked in the output register, even if it is still
// unread.
// Receiver stall: a finished query waits in the output register and the
// next query holds its final step until that register frees up.
// Reset clears the configuration registers and control; table contents
// are undefined until loaded. Write configuration only while idle.
module monthly_index_table_interpolator_unit import mitint_pkg::*; #(
  parameter int TABLE_DEPTH = MITINT_TABLE_DEPTH,
  parameter int FRAC_BITS   = MITINT_FRAC_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  mitint_req_t          in_req_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output mitint_res_t          out_res_o
);

  mitint_cmd_t cmd;
  mitint_sts_t sts;

  // Sequencer: walks a query through year split, month walk, table reads,
  // multiply and divide
  mitint_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_kind_i   (in_req_i.kind),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: configuration, table memory, arithmetic and result register
  mitint_dp #(.TABLE_DEPTH(TABLE_DEPTH), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_req_i   (in_req_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_res_o  (out_res_o)
  );

endmodule

/* bench/tb_monthly_index_table_interpolator_unit.sv */
`timescale 1ns / 1ps

module tb_monthly_index_table_interpolator_unit import mitint_pkg::*; ();

  localparam int          PERIOD       = 20;
  localparam int          RESET_CYCLES = 11;
  // Settle time after the last result, longer than the longest query.
  localparam int          SETTLE       = 60;
  localparam int          HOLD_OFF     = 400;
  localparam int          PHASES       = 8;
  localparam int          PHASE_ITEMS  = 70;
  localparam int unsigned CYCLE_LIMIT  = 3_000_000;
  localparam int          DEPTH        = MITINT_TABLE_DEPTH;
  localparam int          FBITS        = MITINT_FRAC_BITS;

  // Shadow copy of the table and registers; forecasts one result per query
  // and checks the block's results against them in order.
  class index_table_board;
    bit [EFLUX_W-1:0] flux_mem [DEPTH];
    bit [EAP_W-1:0]   ap_mem   [DEPTH];
    int               base_yr;
    int               used_cnt;
    bit               ovr_on;
    int               ovr_fd;
    int               ovr_fa;
    int               ovr_ap;
    int               errors;
    mitint_res_t      due_lookups [$];

    function bit is_leap(int y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function int valid_count();
      return (used_cnt > DEPTH) ? DEPTH : used_cnt;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_BASE_YEAR:      base_yr  = int'(val[YEAR_W-1:0]);
        CFG_ENTRIES_USED:   used_cnt = int'(val[USED_W-1:0]);
        CFG_OVR_ENABLE:     ovr_on   = val[0];
        CFG_OVR_FLUX_DAILY: ovr_fd   = int'(val[FLUX_W-1:0]);
        CFG_OVR_FLUX_AVG:   ovr_fa   = int'(val[FLUX_W-1:0]);
        CFG_OVR_AP:         ovr_ap   = int'(val[AP_W-1:0]);
        default: ;
      endcase
    endfunction

    // Linear blend of two monthly values at day dom of a month of len days.
    function longint ramp(longint a, longint b, int dom, int len, longint cap);
      longint k;
      longint v;
      k = dom - 1;
      v = ((a * (len - k) + b * k) << FBITS) / len;
      return (v > cap) ? cap : v;
    endfunction

    function mitint_res_t lookup_day(mitint_req_t r);
      int          mdays [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      mitint_res_t res;
      int          day;
      int          year;
      int          month;
      int          len;
      int          cnt;
      int          idx;
      int          nxt;
      int          pts;
      bit          leap;
      longint      fsum;
      longint      avg;
      res  = '0;
      day  = int'(r.day_of_year);
      year = int'(r.query_year);
      leap = is_leap(year);
      mdays[1] = leap ? 29 : 28;
      if (day == 0 || day > (leap ? 366 : 365)) begin
        res.status = STATUS_BAD_DAY;
        return res;
      end
      month = 0;
      while (day > mdays[month]) begin
        day -= mdays[month];
        month++;
      end
      len = mdays[month];
      res.status       = STATUS_OK;
      res.month_number = 4'(month + 1);
      res.day_of_month = 5'(day);
      res.month_length = 5'(len);
      if (ovr_on) begin
        res.flux_daily = FLUX_W'(ovr_fd);
        res.flux_avg   = FLUX_W'(ovr_fa);
        res.ap_daily   = AP_W'(ovr_ap);
        return res;
      end
      cnt = valid_count();
      idx = month + 12 * (year - base_yr);
      if (year < base_yr || idx >= cnt) begin
        res.status = STATUS_OUTSIDE;
        return res;
      end
      nxt = (idx + 1 < cnt) ? idx + 1 : idx;
      res.flux_daily = FLUX_W'(ramp(flux_mem[idx], flux_mem[nxt], day, len,
                                    (1 << FLUX_W) - 1));
      res.ap_daily   = AP_W'(ramp(ap_mem[idx], ap_mem[nxt], day, len, (1 << AP_W) - 1));
      fsum = flux_mem[idx];
      pts  = 1;
      if (idx >= 1) begin
        fsum += flux_mem[idx - 1];
        pts++;
      end
      if (idx + 1 < cnt) begin
        fsum += flux_mem[idx + 1];
        pts++;
      end
      avg = (fsum << FBITS) / pts;
      res.flux_avg = FLUX_W'((avg > (1 << FLUX_W) - 1) ? (1 << FLUX_W) - 1 : avg);
      return res;
    endfunction

    function void note_request(mitint_req_t r);
      if (r.kind == 1'b0) begin
        flux_mem[r.entry_index] = r.entry_flux;
        ap_mem[r.entry_index]   = r.entry_ap;
      end else begin
        due_lookups.push_back(lookup_day(r));
      end
    endfunction

    function void check_result(mitint_res_t got);
      mitint_res_t exp;
      bit          bad;
      if (due_lookups.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("[%0t] result with no query pending: %p", $realtime, got);
        return;
      end
      exp = due_lookups.pop_front();
      bad = (got.status !== exp.status) || (got.month_number !== exp.month_number) ||
            (got.day_of_month !== exp.day_of_month) ||
            (got.month_length !== exp.month_length) ||
            (got.flux_daily !== exp.flux_daily) || (got.flux_avg !== exp.flux_avg) ||
            (got.ap_daily !== exp.ap_daily);
      if (bad) begin
        errors++;
        if (errors <= 10) begin
          $display("[%0t] mismatch exp st=%0d mo=%0d dom=%0d len=%0d fd=%0d fa=%0d ap=%0d",
                   $realtime, exp.status, exp.month_number, exp.day_of_month,
                   exp.month_length, exp.flux_daily, exp.flux_avg, exp.ap_daily);
          $display("          got st=%0d mo=%0d dom=%0d len=%0d fd=%0d fa=%0d ap=%0d",
                   got.status, got.month_number, got.day_of_month,
                   got.month_length, got.flux_daily, got.flux_avg, got.ap_daily);
        end
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  mitint_req_t          in_req_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  mitint_res_t          out_res_o;

  index_table_board board = new;
  bit               hold_output_req;
  int unsigned      cycle_count;
  int               calm_left;

  monthly_index_table_interpolator_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (out_res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #(PERIOD / 2) clk_i = ~clk_i;
  end

  // Watchdog: end the run if the block hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Observe both handshakes at the rising edge; inputs only move on the
  // falling edge, so the values seen here are the ones the block takes.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) board.check_result(out_res_o);
      if (in_valid_i && in_ready_o) board.note_request(in_req_i);
    end
  end

  // Result side: mix ready runs, short flickers and the odd long stall.
  // A hold-off request from the stimulus blocks the output; HOLD_OFF sets how long.
  initial begin
    int n;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_output_req) begin
        hold_output_req = 1'b0;
        repeat (HOLD_OFF) begin
          @(negedge clk_i);
          out_ready_i <= 1'b0;
        end
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2: begin
            repeat (40) begin
              @(negedge clk_i);
              out_ready_i <= 1'b1;
            end
          end
          9: begin
            n = $urandom_range(20, 120);
            repeat (n) begin
              @(negedge clk_i);
              out_ready_i <= 1'b0;
            end
          end
          default: begin
            n = $urandom_range(1, 3);
            repeat (n) begin
              @(negedge clk_i);
              out_ready_i <= 1'b0;
            end
            n = $urandom_range(1, 6);
            repeat (n) begin
              @(negedge clk_i);
              out_ready_i <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  // Build a request; fields the kind ignores carry random bits.
  function automatic mitint_req_t make_query(int day, int year);
    logic [63:0] raw;
    mitint_req_t r;
    raw           = {$urandom, $urandom};
    r             = raw[$bits(mitint_req_t)-1:0];
    r.kind        = 1'b1;
    r.day_of_year = DAY_W'(day);
    r.query_year  = YEAR_W'(year);
    return r;
  endfunction

  function automatic mitint_req_t make_load(int slot, int flux, int ap);
    logic [63:0] raw;
    mitint_req_t r;
    raw           = {$urandom, $urandom};
    r             = raw[$bits(mitint_req_t)-1:0];
    r.kind        = 1'b0;
    r.entry_index = EIDX_W'(slot);
    r.entry_flux  = EFLUX_W'(flux);
    r.entry_ap    = EAP_W'(ap);
    return r;
  endfunction

  function automatic mitint_req_t random_load();
    return make_load($urandom_range(0, DEPTH - 1), $urandom_range(0, 1023),
                     $urandom_range(0, 511));
  endfunction

  // Aim most queries inside the loaded span; spill some before, after and
  // across the whole year field, and poke the ends of the year.
  function automatic mitint_req_t random_query();
    int y;
    int ylen;
    int d;
    case ($urandom_range(0, 19))
      0:       y = $urandom_range(0, (1 << YEAR_W) - 1);
      1:       y = (board.base_yr > 0) ? board.base_yr - 1 : $urandom_range(0, 50);
      default: y = board.base_yr + $urandom_range(0, board.valid_count() / 12 + 1);
    endcase
    if (y > (1 << YEAR_W) - 1) y = (1 << YEAR_W) - 1;
    ylen = board.is_leap(y) ? 366 : 365;
    case ($urandom_range(0, 15))
      0:       d = $urandom_range(0, (1 << DAY_W) - 1);
      1:       d = 0;
      2:       d = ylen;
      3:       d = ylen + 1;
      default: d = $urandom_range(1, ylen);
    endcase
    return make_query(d, y);
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones, and now and then
  // a calm run of thirty-one requests with no gap at all.
  function automatic int pick_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 31);
    if (r < 18) return 0;
    if (r < 29) return $urandom_range(1, 3);
    if (r == 29) calm_left = 30;
    if (r == 30) return $urandom_range(4, 10);
    if (r == 31) return $urandom_range(20, 60);
    return 0;
  endfunction

  task automatic send_request(mitint_req_t r, int gap);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    // Hold until the block takes it.
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drop valid, wait out every pending result, then let the block settle.
  task automatic drain_lookups();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board.due_lookups.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    board.set_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic write_all(int base, int used, bit ovr, int fd, int fa, int ap);
    write_reg(CFG_BASE_YEAR, CFG_W'(base));
    write_reg(CFG_ENTRIES_USED, CFG_W'(used));
    write_reg(CFG_OVR_ENABLE, CFG_W'(ovr));
    write_reg(CFG_OVR_FLUX_DAILY, CFG_W'(fd));
    write_reg(CFG_OVR_FLUX_AVG, CFG_W'(fa));
    write_reg(CFG_OVR_AP, CFG_W'(ap));
  endtask

  // Register settings per random phase; extremes first, then random mixes.
  task automatic apply_setting(int p);
    case (p)
      0: write_all(2000, DEPTH, 1'b0, 0, 0, 0);
      1: write_all(0, 0, 1'b0, 0, 0, 0);
      2: write_all(9999, (1 << USED_W) - 1, 1'b0, 0, 0, 0);
      3: write_all($urandom_range(0, 9999), DEPTH, 1'b1,
                   (1 << FLUX_W) - 1, (1 << FLUX_W) - 1, (1 << CFG_W) - 1);
      4: write_all((1 << YEAR_W) - 1, 1, 1'b0, 0, 0, 0);
      5: write_all($urandom_range(1900, 2100), $urandom_range(0, DEPTH), 1'b1,
                   $urandom_range(0, 261888), $urandom_range(0, 261888),
                   $urandom_range(0, 130816));
      6: write_all($urandom_range(1900, 2100), $urandom_range(1, DEPTH), 1'b0,
                   $urandom_range(0, 261888), 0, 0);
      default: write_all($urandom_range(0, 9999), 13, 1'b0, 0, 0, 0);
    endcase
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = '0;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    in_req_i        = '0;
    hold_output_req = 1'b0;
    calm_left       = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Load every slot up front so no query ever reads an unwritten entry;
    // slot 0 holds the minimum and the top slot the maximum.
    apply_setting(0);
    send_request(make_load(0, 0, 0), 0);
    for (int s = 1; s < DEPTH - 1; s++)
      send_request(make_load(s, $urandom_range(0, 1023), $urandom_range(0, 511)),
                   pick_gap());
    send_request(make_load(DEPTH - 1, 1023, 511), 0);

    // Directed dates against base year 2000 with a full table.
    send_request(make_query(1, 2000), 0);      // first entry, no previous month
    send_request(make_query(32, 2000), 1);     // first of February
    send_request(make_query(60, 2000), 0);     // leap day
    send_request(make_query(59, 2001), 2);     // last of February, common year
    send_request(make_query(366, 2000), 0);    // last day of a leap year
    send_request(make_query(366, 2001), 0);    // day past a common year
    send_request(make_query(366, 1900), 3);    // century year, not leap
    send_request(make_query(366, 2400), 0);    // leap by 400, far outside table
    send_request(make_query(0, 2000), 0);      // day zero
    send_request(make_query(511, 2004), 0);    // day field all ones
    send_request(make_query(90, 2085), 0);     // next month still loaded
    send_request(make_query(100, 2085), 0);    // last valid entry, flat ramp
    send_request(make_query(121, 2085), 5);    // one month past the table
    send_request(make_query(15, 1999), 0);     // year before base
    send_request(make_query(200, (1 << YEAR_W) - 1), 0);
    send_request(make_query(200, 0), 0);
    send_request(make_load(DEPTH - 1, 512, 256), 0);
    send_request(make_query(110, 2085), 0);    // reads the slot just reloaded
    drain_lookups();

    for (int p = 0; p < PHASES; p++) begin
      apply_setting(p);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 0 && i == 30) begin
          // Block the output and keep offering queries until the input stalls.
          hold_output_req = 1'b1;
          repeat (10) send_request(random_query(), 0);
        end
        if (p == 2 && i == 50) drain_lookups();
        if ($urandom_range(0, 9) < 3)
          send_request(random_load(), pick_gap());
        else
          send_request(random_query(), pick_gap());
      end
      drain_lookups();
    end

    if (board.errors == 0 && board.due_lookups.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
